// File: hw/rtl/bwa_pkg.sv
// ----------------------------------------------------------------------------
// bwa_pkg
// Shared opcodes, widths and transfer types for the byte/word NZVC ALU.
// ----------------------------------------------------------------------------
package bwa_pkg;

   localparam int DATA_W = 16;
   localparam int OP_W   = 4;

   localparam logic [OP_W-1:0] OP_PASS  = 4'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 4'd1;
   localparam logic [OP_W-1:0] OP_ADDC  = 4'd2;
   localparam logic [OP_W-1:0] OP_SUB   = 4'd3;
   localparam logic [OP_W-1:0] OP_SUBC  = 4'd4;
   localparam logic [OP_W-1:0] OP_AND   = 4'd5;
   localparam logic [OP_W-1:0] OP_NAND  = 4'd6;
   localparam logic [OP_W-1:0] OP_OR    = 4'd7;
   localparam logic [OP_W-1:0] OP_NOR   = 4'd8;
   localparam logic [OP_W-1:0] OP_XOR   = 4'd9;
   localparam logic [OP_W-1:0] OP_NOT   = 4'd10;
   localparam logic [OP_W-1:0] OP_ASL   = 4'd11;
   localparam logic [OP_W-1:0] OP_ROL   = 4'd12;
   localparam logic [OP_W-1:0] OP_ASR   = 4'd13;
   localparam logic [OP_W-1:0] OP_ROR   = 4'd14;
   localparam logic [OP_W-1:0] OP_FLAGS = 4'd15;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic              wide;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
      logic              carry_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result;
      logic              flag_n;
      logic              flag_z;
      logic              flag_v;
      logic              flag_c;
   } rsp_type;

endpackage

// File: hw/rtl/bwa_in_reg.sv
// ----------------------------------------------------------------------------
// bwa_in_reg
// Input register: captures one request per accepted transfer.
// ----------------------------------------------------------------------------
module bwa_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  bwa_pkg::req_type req,
   output logic             valid,
   output bwa_pkg::req_type req_q
);

   logic             valid_ff;
   logic             valid_in;
   bwa_pkg::req_type req_ff;
   bwa_pkg::req_type req_in;

   assign valid_in = accept;
   assign req_in   = accept ? req : req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   assign valid = valid_ff;
   assign req_q = req_ff;

endmodule

// File: hw/rtl/bwa_exec.sv
// ----------------------------------------------------------------------------
// bwa_exec
// Combinational ALU: one of sixteen operations at byte or word width, with
// N, Z, V and C flags.
// ----------------------------------------------------------------------------
module bwa_exec (
   input  bwa_pkg::req_type req,
   output bwa_pkg::rsp_type rsp
);

   localparam int W = bwa_pkg::DATA_W;

   logic [W-1:0] mask;
   logic [W-1:0] top;
   logic [W-1:0] a;
   logic [W-1:0] b;
   logic [W-1:0] bb;
   logic         ci;
   logic [W:0]   sum;
   logic [W-1:0] r;
   logic         v;
   logic         c;
   logic         a_top;
   logic         r_top;
   logic         bb_top;
   logic         sub_op;
   logic         shift_in;
   logic         flags_op;

   assign mask = req.wide ? {W{1'b1}} : {{(W/2){1'b0}}, {(W/2){1'b1}}};
   assign top  = req.wide ? {1'b1, {(W-1){1'b0}}} : {{(W/2){1'b0}}, 1'b1, {(W/2-1){1'b0}}};
   assign a    = req.operand_a & mask;
   assign b    = req.operand_b & mask;

   assign sub_op = (req.operation == bwa_pkg::OP_SUB) || (req.operation == bwa_pkg::OP_SUBC);
   assign bb     = sub_op ? (~b & mask) : b;

   always_comb begin
      unique case (req.operation)
         bwa_pkg::OP_ADD: ci = 1'b0;
         bwa_pkg::OP_SUB: ci = 1'b1;
         default:         ci = req.carry_in;
      endcase
   end

   assign sum = {1'b0, a} + {1'b0, bb} + {{W{1'b0}}, ci};

   assign a_top  = |(a & top);
   assign bb_top = |(bb & top);
   assign r_top  = |(r & top);

   // asr refills the top with the old sign, ror with the carry
   assign shift_in = (req.operation == bwa_pkg::OP_ROR) ? req.carry_in : a_top;

   always_comb begin
      r = a;
      v = 1'b0;
      c = 1'b0;
      unique case (req.operation)
         bwa_pkg::OP_PASS: begin
            r = a;
         end
         bwa_pkg::OP_ADD, bwa_pkg::OP_ADDC, bwa_pkg::OP_SUB, bwa_pkg::OP_SUBC: begin
            r = sum[W-1:0] & mask;
            c = req.wide ? sum[W] : sum[W/2];
            v = ~(a_top ^ bb_top) & (a_top ^ (req.wide ? sum[W-1] : sum[W/2-1]));
         end
         bwa_pkg::OP_AND:  r = a & b;
         bwa_pkg::OP_NAND: r = ~(a & b) & mask;
         bwa_pkg::OP_OR:   r = a | b;
         bwa_pkg::OP_NOR:  r = ~(a | b) & mask;
         bwa_pkg::OP_XOR:  r = a ^ b;
         bwa_pkg::OP_NOT:  r = ~a & mask;
         bwa_pkg::OP_ASL, bwa_pkg::OP_ROL: begin
            r = {a[W-2:0],
                 (req.operation == bwa_pkg::OP_ROL) ? req.carry_in : 1'b0} & mask;
            c = a_top;
            v = a_top ^ (req.wide ? a[W-2] : a[W/2-2]);
         end
         bwa_pkg::OP_ASR, bwa_pkg::OP_ROR: begin
            r = ({1'b0, a[W-1:1]} | (shift_in ? top : {W{1'b0}})) & mask;
            c = a[0];
         end
         bwa_pkg::OP_FLAGS: begin
            r = {W{1'b0}};
         end
      endcase
   end

   assign flags_op = (req.operation == bwa_pkg::OP_FLAGS);

   assign rsp.result = r;
   assign rsp.flag_n = flags_op ? a[3] : r_top;
   assign rsp.flag_z = flags_op ? a[2] : (r == {W{1'b0}});
   assign rsp.flag_v = flags_op ? a[1] : v;
   assign rsp.flag_c = flags_op ? a[0] : c;

endmodule

// File: hw/rtl/bwa_out_reg.sv
// ----------------------------------------------------------------------------
// bwa_out_reg
// Result register: holds the last result until the next one; its strobe is high for one cycle per result.
// ----------------------------------------------------------------------------
module bwa_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             valid,
   input  bwa_pkg::rsp_type rsp,
   output logic             rsp_valid,
   output bwa_pkg::rsp_type rsp_q
);

   logic             valid_ff;
   logic             valid_in;
   bwa_pkg::rsp_type rsp_ff;
   bwa_pkg::rsp_type rsp_in;

   assign valid_in = valid;
   assign rsp_in   = valid ? rsp : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_q     = rsp_ff;

endmodule

// File: hw/rtl/byte_word_alu_nzvc_top.sv
// ----------------------------------------------------------------------------
// byte_word_alu_nzvc_top
// Byte/word ALU with N, Z, V and C flags, one operation per clock while busy is low.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge where start is high and busy is low;
// busy is high during reset and in the cycle after it, so one operation per
// cycle is sustained. Each result appears once its transfer has passed the
// input register and the result register around the single-pass ALU logic,
// for exactly one cycle, marked by rsp_valid; the receiver cannot stall it
// and must take it then.
module byte_word_alu_nzvc_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_operation,
   input  logic        req_wide,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   input  logic        req_carry_in,
   output logic        rsp_valid,
   output logic [15:0] rsp_result,
   output logic        rsp_flag_n,
   output logic        rsp_flag_z,
   output logic        rsp_flag_v,
   output logic        rsp_flag_c
);

   logic             busy_ff;
   logic             busy_in;
   logic             accept;
   logic             stage_valid;
   bwa_pkg::req_type req;
   bwa_pkg::req_type req_q;
   bwa_pkg::rsp_type rsp;
   bwa_pkg::rsp_type rsp_q;

   assign busy_in = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   assign req.operation = req_operation;
   assign req.wide      = req_wide;
   assign req.operand_a = req_operand_a;
   assign req.operand_b = req_operand_b;
   assign req.carry_in  = req_carry_in;

   bwa_in_reg u_in_reg (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req),
      .valid (stage_valid),
      .req_q (req_q)
   );

   bwa_exec u_exec (
      .req(req_q),
      .rsp(rsp)
   );

   bwa_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .valid    (stage_valid),
      .rsp      (rsp),
      .rsp_valid(rsp_valid),
      .rsp_q    (rsp_q)
   );

   assign rsp_result = rsp_q.result;
   assign rsp_flag_n = rsp_q.flag_n;
   assign rsp_flag_z = rsp_q.flag_z;
   assign rsp_flag_v = rsp_q.flag_v;
   assign rsp_flag_c = rsp_q.flag_c;

endmodule

// File: hw/rtl/bwa_checker.sv
// ----------------------------------------------------------------------------
// bwa_checker
// Port-level checks for the byte/word NZVC ALU, bound to the top level.
// ----------------------------------------------------------------------------
module bwa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [3:0]  req_operation,
   input logic        req_wide,
   input logic        rsp_valid,
   input logic [15:0] rsp_result,
   input logic        rsp_flag_z
);

   // every transfer yields a result after the input and result registers
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("missing result after transfer");

   // no result without an earlier transfer
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without transfer");

   // byte results keep the upper byte clear
   a_byte_upper: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(req_wide, 2)) |-> (rsp_result[15:8] == 8'd0))
      else $error("upper byte set in byte mode");

   // zero flag tracks the result except for flag unpack
   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_operation, 2) != bwa_pkg::OP_FLAGS))
         |-> (rsp_flag_z == (rsp_result == 16'd0)))
      else $error("zero flag mismatch");

   // flag unpack returns a zero result
   a_flags_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_operation, 2) == bwa_pkg::OP_FLAGS))
         |-> (rsp_result == 16'd0))
      else $error("flag unpack result not zero");

endmodule

bind byte_word_alu_nzvc_top bwa_checker u_bwa_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_operation(req_operation),
   .req_wide     (req_wide),
   .rsp_valid    (rsp_valid),
   .rsp_result   (rsp_result),
   .rsp_flag_z   (rsp_flag_z)
);
